@@ hw/rtl/brainfuck_interpreter_core_defines.svh @@
// Assertion macros for the RTL of the interpreter core, included by bic_seq.
`ifndef BRAINFUCK_INTERPRETER_CORE_DEFINES_SVH
`define BRAINFUCK_INTERPRETER_CORE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define BIC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Same-cycle implication.
`define BIC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/bic_pkg.sv @@
package bic_pkg;

	// Store sizes
	localparam int PROG_DEPTH = 256;
	localparam int TAPE_DEPTH = 256;
	localparam int PAW = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
	localparam int PLW = PAW + 1;
	localparam int TAW = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;

	// Command codes
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_START  = 2'd1;
	localparam logic [1:0] OP_STEP   = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_END       = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_UNMATCHED = 2'd3;

	// Instruction characters
	localparam logic [7:0] CH_OPEN  = 8'h5B; // '['
	localparam logic [7:0] CH_CLOSE = 8'h5D; // ']'
	localparam logic [7:0] CH_RIGHT = 8'h3E; // '>'
	localparam logic [7:0] CH_LEFT  = 8'h3C; // '<'
	localparam logic [7:0] CH_INC   = 8'h2B; // '+'
	localparam logic [7:0] CH_DEC   = 8'h2D; // '-'
	localparam logic [7:0] CH_OUT   = 8'h2E; // '.'

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic [1:0] status;
	} rsp_data_t;

	typedef struct packed {
		logic      valid;
		rsp_data_t data;
	} res_t;

	typedef struct packed {
		logic           we;
		logic [PAW-1:0] waddr;
		logic [7:0]     wdata;
		logic           re;
		logic [PAW-1:0] raddr;
	} prog_req_t;

	typedef struct packed {
		logic           we;
		logic [TAW-1:0] waddr;
		logic [7:0]     wdata;
		logic           re;
		logic [TAW-1:0] raddr;
	} tape_req_t;

endpackage

@@ hw/rtl/bic_ram.sv @@
module bic_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/bic_seq.sv @@
`include "brainfuck_interpreter_core_defines.svh"

module bic_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic [1:0]         op,
	input  logic [7:0]         instr_char,
	output bic_pkg::prog_req_t prog_req,
	input  logic [7:0]         prog_rdata,
	output bic_pkg::tape_req_t tape_req,
	input  logic [7:0]         tape_rdata,
	output bic_pkg::res_t      res,
	input  logic               res_take
);

	import bic_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CLR  = 5'b00010,
		S_EXEC = 5'b00100,
		S_SCAN = 5'b01000,
		S_RESP = 5'b10000
	} state_t;

	state_t         state_q, state_d;
	logic [PLW-1:0] len_q, len_d;
	logic [PLW-1:0] pc_q, pc_d;
	logic [TAW-1:0] dp_q, dp_d;
	logic [TAW-1:0] clr_q, clr_d;
	logic           clr_rsp_q, clr_rsp_d;
	logic [PLW-1:0] chk_q, chk_d;
	logic [PLW-1:0] depth_q, depth_d;
	logic           fwd_q, fwd_d;
	rsp_data_t      res_q, res_d;

	logic [PLW-1:0] pc_inc;
	logic [PLW-1:0] chk_nxt;
	logic [7:0]     nest_ch;
	logic [7:0]     match_ch;

	assign cmd_ready  = (state_q == S_IDLE);
	assign res.valid  = (state_q == S_RESP);
	assign res.data   = res_q;
	assign pc_inc     = pc_q + PLW'(1);
	assign chk_nxt    = fwd_q ? (chk_q + PLW'(1)) : (chk_q - PLW'(1));
	assign nest_ch    = fwd_q ? CH_OPEN : CH_CLOSE;
	assign match_ch   = fwd_q ? CH_CLOSE : CH_OPEN;

	// Next-state and memory request logic
	always_comb begin
		state_d   = state_q;
		len_d     = len_q;
		pc_d      = pc_q;
		dp_d      = dp_q;
		clr_d     = clr_q;
		clr_rsp_d = clr_rsp_q;
		chk_d     = chk_q;
		depth_d   = depth_q;
		fwd_d     = fwd_q;
		res_d     = res_q;
		prog_req  = '0;
		tape_req  = '0;

		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					res_d.out_valid = 1'b0;
					res_d.out_byte  = '0;
					res_d.status    = ST_OK;
					state_d         = S_RESP;
					case (op)
						OP_APPEND: begin
							if (len_q == PLW'(PROG_DEPTH)) begin
								res_d.status = ST_FULL;
							end else begin
								prog_req.we    = 1'b1;
								prog_req.waddr = len_q[PAW-1:0];
								prog_req.wdata = instr_char;
								len_d          = len_q + PLW'(1);
							end
						end
						OP_START: begin
							pc_d      = '0;
							dp_d      = '0;
							clr_d     = '0;
							clr_rsp_d = 1'b1;
							state_d   = S_CLR;
						end
						OP_CLEAR: begin
							len_d = '0;
							pc_d  = '0;
						end
						default: begin
							if (pc_q >= len_q) begin
								res_d.status = ST_END;
							end else begin
								prog_req.re    = 1'b1;
								prog_req.raddr = pc_q[PAW-1:0];
								tape_req.re    = 1'b1;
								tape_req.raddr = dp_q;
								state_d        = S_EXEC;
							end
						end
					endcase
				end
			end

			// Tape clearing sweep, one cell a cycle
			S_CLR: begin
				tape_req.we    = 1'b1;
				tape_req.waddr = clr_q;
				tape_req.wdata = '0;
				if (clr_q == TAW'(TAPE_DEPTH - 1)) begin
					state_d   = clr_rsp_q ? S_RESP : S_IDLE;
					clr_rsp_d = 1'b0;
				end else begin
					clr_d = clr_q + TAW'(1);
				end
			end

			// Instruction and cell data are back from the memories
			S_EXEC: begin
				state_d = S_RESP;
				pc_d    = pc_inc;
				case (prog_rdata)
					CH_RIGHT: begin
						dp_d = (dp_q == TAW'(TAPE_DEPTH - 1)) ? '0 : dp_q + TAW'(1);
					end
					CH_LEFT: begin
						dp_d = (dp_q == '0) ? TAW'(TAPE_DEPTH - 1) : dp_q - TAW'(1);
					end
					CH_INC: begin
						tape_req.we    = 1'b1;
						tape_req.waddr = dp_q;
						tape_req.wdata = tape_rdata + 8'd1;
					end
					CH_DEC: begin
						tape_req.we    = 1'b1;
						tape_req.waddr = dp_q;
						tape_req.wdata = tape_rdata - 8'd1;
					end
					CH_OUT: begin
						res_d.out_valid = 1'b1;
						res_d.out_byte  = tape_rdata;
					end
					CH_OPEN: begin
						if (tape_rdata == 8'd0) begin
							if (pc_inc >= len_q) begin
								res_d.status = ST_UNMATCHED;
								pc_d         = pc_q;
							end else begin
								// counter stays on the bracket until a match is found
								prog_req.re    = 1'b1;
								prog_req.raddr = pc_inc[PAW-1:0];
								pc_d           = pc_q;
								chk_d          = pc_inc;
								depth_d        = PLW'(1);
								fwd_d          = 1'b1;
								state_d        = S_SCAN;
							end
						end
					end
					CH_CLOSE: begin
						if (tape_rdata != 8'd0) begin
							if (pc_q == '0) begin
								res_d.status = ST_UNMATCHED;
								pc_d         = pc_q;
							end else begin
								prog_req.re    = 1'b1;
								prog_req.raddr = pc_q[PAW-1:0] - PAW'(1);
								pc_d           = pc_q;
								chk_d          = pc_q - PLW'(1);
								depth_d        = PLW'(1);
								fwd_d          = 1'b0;
								state_d        = S_SCAN;
							end
						end
					end
					default: begin
					end
				endcase
			end

			// Bracket scan: one program byte checked per cycle, next read in flight
			S_SCAN: begin
				if (prog_rdata == match_ch && depth_q == PLW'(1)) begin
					pc_d    = chk_q + PLW'(1);
					state_d = S_RESP;
				end else begin
					if (prog_rdata == nest_ch) begin
						depth_d = depth_q + PLW'(1);
					end else if (prog_rdata == match_ch) begin
						depth_d = depth_q - PLW'(1);
					end
					if ((fwd_q && chk_nxt >= len_q) || (!fwd_q && chk_q == '0)) begin
						res_d.status = ST_UNMATCHED;
						state_d      = S_RESP;
					end else begin
						prog_req.re    = 1'b1;
						prog_req.raddr = chk_nxt[PAW-1:0];
						chk_d          = chk_nxt;
					end
				end
			end

			S_RESP: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state; reset starts with a tape clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			len_q     <= '0;
			pc_q      <= '0;
			dp_q      <= '0;
			clr_q     <= '0;
			clr_rsp_q <= 1'b0;
			chk_q     <= '0;
			depth_q   <= '0;
			fwd_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			len_q     <= len_d;
			pc_q      <= pc_d;
			dp_q      <= dp_d;
			clr_q     <= clr_d;
			clr_rsp_q <= clr_rsp_d;
			chk_q     <= chk_d;
			depth_q   <= depth_d;
			fwd_q     <= fwd_d;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	`BIC_ASSERT_ALWAYS(a_pc_le_len, pc_q <= len_q, "program counter past program length")
	`BIC_ASSERT_ALWAYS(a_len_le_depth, len_q <= PLW'(PROG_DEPTH), "program length overflow")
	`BIC_ASSERT_IMP(a_prog_we_append, prog_req.we,
		cmd_valid && cmd_ready && op == OP_APPEND, "program write outside an append")
	`BIC_ASSERT_IMP(a_tape_rw_excl, tape_req.re, !tape_req.we, "tape read and write overlap")
	`BIC_ASSERT_IMP(a_scan_in_program, state_q == S_SCAN, chk_q < len_q,
		"bracket scan outside the program")

endmodule

@@ hw/rtl/brainfuck_interpreter_core.sv @@
// Tape-language interpreter core. Each command transfer yields exactly one response.
// A plain step reads the program and the tape, then executes and writes the tape back. A
// taken bracket then scans the program one byte at a time, through the one read port of
// the program memory. Start clears the tape one cell a cycle. After reset the same
// clearing sweep runs, during which cmd_ready is low. A response waits in an output
// register, so the next command is taken while it is still pending on rsp_ready.
module brainfuck_interpreter_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  logic [1:0] op,
	input  logic [7:0] instr_char,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic [1:0] status
);

	import bic_pkg::*;

	prog_req_t prog_req;
	tape_req_t tape_req;
	logic [7:0] prog_rdata;
	logic [7:0] tape_rdata;
	res_t       res;
	logic       res_take;
	logic       rsp_valid_q;
	rsp_data_t  rsp_q;

	bic_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.op         (op),
		.instr_char (instr_char),
		.prog_req   (prog_req),
		.prog_rdata (prog_rdata),
		.tape_req   (tape_req),
		.tape_rdata (tape_rdata),
		.res        (res),
		.res_take   (res_take)
	);

	bic_ram #(.DEPTH(PROG_DEPTH), .WIDTH(8)) u_prog_ram (
		.clk   (clk),
		.we    (prog_req.we),
		.waddr (prog_req.waddr),
		.wdata (prog_req.wdata),
		.re    (prog_req.re),
		.raddr (prog_req.raddr),
		.rdata (prog_rdata)
	);

	bic_ram #(.DEPTH(TAPE_DEPTH), .WIDTH(8)) u_tape_ram (
		.clk   (clk),
		.we    (tape_req.we),
		.waddr (tape_req.waddr),
		.wdata (tape_req.wdata),
		.re    (tape_req.re),
		.raddr (tape_req.raddr),
		.rdata (tape_rdata)
	);

	// Output register loads when empty or draining
	assign res_take = res.valid && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res.data;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign out_valid = rsp_q.out_valid;
	assign out_byte  = rsp_q.out_byte;
	assign status    = rsp_q.status;

endmodule
